/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked assertion, disabled while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: when the antecedent holds, the consequent holds too.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle form: when the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mesp_pkg.sv */
// ----------------------------------------------------------------------------
// mesp_pkg
// Types and constants of the music event stream parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mesp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned OffW   = 16;
  localparam int unsigned TdataW = 80;

  // parser phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_PARAM1 = 3'd1;
  localparam logic [2:0] PH_VOLUME = 3'd2;
  localparam logic [2:0] PH_CVALUE = 3'd3;
  localparam logic [2:0] PH_DELAY  = 3'd4;

  typedef enum logic [2:0] {
    EV_RELEASE    = 3'd0,
    EV_PLAY       = 3'd1,
    EV_BEND       = 3'd2,
    EV_SYSTEM     = 3'd3,
    EV_CONTROLLER = 3'd4,
    EV_MEASURE    = 3'd5,
    EV_FINISH     = 3'd6,
    EV_UNUSED     = 3'd7
  } mesp_event_e;

  localparam logic RK_EVENT = 1'b0;
  localparam logic RK_DELAY = 1'b1;

  typedef struct packed {
    logic            result_kind;
    logic [2:0]      event_kind;
    logic [3:0]      channel_number;
    logic [6:0]      note_number;
    logic [6:0]      volume_level;
    logic            volume_present;
    logic [7:0]      bend_amount;
    logic [6:0]      controller_number;
    logic [6:0]      controller_value;
    logic            group_last;
    logic [OffW-1:0] event_offset;
    logic [OffW-1:0] delay_ticks;
  } mesp_result_t;

endpackage

`default_nettype wire

/* hdl/mus_event_stream_parser_unit.sv */
// ----------------------------------------------------------------------------
// mus_event_stream_parser_unit
// Byte-stream parser for music score events and variable-length delays.
// ----------------------------------------------------------------------------
// Takes one score byte per beat and accepts a byte every clock while the
// output is not stalled. Each byte passes an input register, a single decode
// step against the parser phase, and a result register, which holds the
// result beat of the byte that completes it. Header and first-parameter bytes
// of multi-byte events, and delay continuation bytes, give no beat. Event
// beats carry the offset of their header byte; delay beats carry the delay
// modulo 65536 with all event fields zero. Rate is one byte per cycle.
`timescale 1ns / 1ps
`default_nettype none

module mus_event_stream_parser_unit
  import mesp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [ByteW-1:0]  s_axis_tdata,  // [7:0] score_byte
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [2:0] event_kind, [6:3] channel_number, [13:7] note_number,
  // [20:14] volume_level, [21] volume_present, [29:22] bend_amount,
  // [36:30] controller_number, [43:37] controller_value,
  // [59:44] event_offset, [75:60] delay_ticks, [79:76] zero
  output logic [TdataW-1:0]      m_axis_tdata,
  output logic                   m_axis_tlast,  // group_last
  output logic                   m_axis_tuser   // result_kind
);

  logic             advance;
  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             res_valid;
  mesp_result_t     res;
  mesp_result_t     out_res;

  mesp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .advance_i  (advance),
    .valid_o    (in_valid),
    .byte_o     (in_byte)
  );

  mesp_decode u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .consume_i   (in_valid && advance),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mesp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_valid_i (in_valid),
    .res_valid_i (res_valid),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_res)
  );

  assign m_axis_tdata = {4'b0000,
                         out_res.delay_ticks,
                         out_res.event_offset,
                         out_res.controller_value,
                         out_res.controller_number,
                         out_res.bend_amount,
                         out_res.volume_present,
                         out_res.volume_level,
                         out_res.note_number,
                         out_res.channel_number,
                         out_res.event_kind};
  assign m_axis_tlast = out_res.group_last;
  assign m_axis_tuser = out_res.result_kind;

endmodule

`default_nettype wire

/* hdl/mesp_in_stage.sv */
// ----------------------------------------------------------------------------
// mesp_in_stage
// Input register for score bytes; refills in the cycle it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mesp_in_stage
  import mesp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] in_byte_i,
  input  wire logic             advance_i,
  output logic                  valid_o,
  output logic [ByteW-1:0]      byte_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

/* hdl/mesp_decode.sv */
// ----------------------------------------------------------------------------
// mesp_decode
// Parser state and per-byte decode of event headers, parameters and delays.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mesp_decode
  import mesp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             consume_i,
  input  wire logic [ByteW-1:0] byte_i,
  output logic                  res_valid_o,
  output mesp_result_t          res_o
);

  logic [2:0]      phase_q, phase_d;
  logic [2:0]      kind_q, kind_d;
  logic [3:0]      chan_q, chan_d;
  logic            last_q, last_d;
  logic [6:0]      param_q, param_d;
  logic [OffW-1:0] acc_q, acc_d;
  logic [OffW-1:0] boff_q, boff_d;
  logic [OffW-1:0] hoff_q, hoff_d;

  logic [6:0]      low7;
  logic [OffW-1:0] acc_next;
  logic            emit;
  logic            emit_delay;
  logic [2:0]      ev_kind;
  logic [3:0]      ev_chan;
  logic            ev_last;
  logic [OffW-1:0] ev_off;
  logic [6:0]      p_note, p_vol, p_cnum, p_cval;
  logic            p_volp;
  logic [7:0]      p_bend;

  assign low7     = byte_i[6:0];
  assign acc_next = {acc_q[OffW-8:0], low7};

  always_comb begin
    phase_d    = phase_q;
    kind_d     = kind_q;
    chan_d     = chan_q;
    last_d     = last_q;
    param_d    = param_q;
    acc_d      = acc_q;
    boff_d     = boff_q + OffW'(1);
    hoff_d     = hoff_q;
    emit       = 1'b0;
    emit_delay = 1'b0;
    ev_kind    = kind_q;
    ev_chan    = chan_q;
    ev_last    = last_q;
    ev_off     = hoff_q;
    p_note     = '0;
    p_vol      = '0;
    p_volp     = 1'b0;
    p_bend     = '0;
    p_cnum     = '0;
    p_cval     = '0;

    unique case (phase_q)
      PH_PARAM1: begin
        case (kind_q)
          EV_RELEASE: begin
            emit   = 1'b1;
            p_note = low7;
          end
          EV_PLAY: begin
            if (byte_i[7]) begin
              param_d = low7;
              phase_d = PH_VOLUME;
            end else begin
              emit   = 1'b1;
              p_note = low7;
            end
          end
          EV_BEND: begin
            emit   = 1'b1;
            p_bend = byte_i;
          end
          EV_SYSTEM: begin
            emit   = 1'b1;
            p_cnum = low7;
          end
          EV_CONTROLLER: begin
            param_d = low7;
            phase_d = PH_CVALUE;
          end
          default: begin
            emit = 1'b1;
          end
        endcase
      end
      PH_VOLUME: begin
        emit   = 1'b1;
        p_note = param_q;
        p_vol  = low7;
        p_volp = 1'b1;
      end
      PH_CVALUE: begin
        emit   = 1'b1;
        p_cnum = param_q;
        p_cval = low7;
      end
      PH_DELAY: begin
        // 7 bits a byte, msb set means more bytes follow
        if (byte_i[7]) begin
          acc_d = acc_next;
        end else begin
          emit_delay = 1'b1;
          acc_d      = '0;
          phase_d    = PH_HEADER;
        end
      end
      default: begin
        hoff_d  = boff_q;
        last_d  = byte_i[7];
        kind_d  = byte_i[6:4];
        chan_d  = byte_i[3:0];
        ev_kind = byte_i[6:4];
        ev_chan = byte_i[3:0];
        ev_last = byte_i[7];
        ev_off  = boff_q;
        if (byte_i[6:4] <= EV_CONTROLLER) begin
          phase_d = PH_PARAM1;
        end else begin
          emit = 1'b1;
        end
      end
    endcase

    if (emit) begin
      if (ev_last) begin
        acc_d   = '0;
        phase_d = PH_DELAY;
      end else begin
        phase_d = PH_HEADER;
      end
    end
  end

  always_comb begin
    res_o = '0;
    if (emit_delay) begin
      res_o.result_kind = RK_DELAY;
      res_o.delay_ticks = acc_next;
    end else begin
      res_o.result_kind       = RK_EVENT;
      res_o.event_kind        = ev_kind;
      res_o.channel_number    = ev_chan;
      res_o.note_number       = p_note;
      res_o.volume_level      = p_vol;
      res_o.volume_present    = p_volp;
      res_o.bend_amount       = p_bend;
      res_o.controller_number = p_cnum;
      res_o.controller_value  = p_cval;
      res_o.group_last        = ev_last;
      res_o.event_offset      = ev_off;
    end
  end

  assign res_valid_o = emit || emit_delay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      kind_q  <= '0;
      chan_q  <= '0;
      last_q  <= 1'b0;
      param_q <= '0;
      acc_q   <= '0;
      boff_q  <= '0;
      hoff_q  <= '0;
    end else if (consume_i) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      chan_q  <= chan_d;
      last_q  <= last_d;
      param_q <= param_d;
      acc_q   <= acc_d;
      boff_q  <= boff_d;
      hoff_q  <= hoff_d;
    end
  end

  `ASSERT_IMPL(a_delay_from_delay_phase, res_valid_o && res_o.result_kind == RK_DELAY,
    phase_q == PH_DELAY, "delay result outside delay phase")
  `ASSERT_NEXT(a_offset_counts, consume_i, boff_q == $past(boff_q) + OffW'(1),
    "byte offset did not advance on consumed byte")
  `ASSERT_IMPL(a_delay_fields_clear, res_valid_o && res_o.result_kind == RK_DELAY,
    res_o.event_offset == '0 && !res_o.group_last && res_o.event_kind == '0,
    "delay result carries event fields")
  `ASSERT_NEXT(a_last_enters_delay, consume_i && res_valid_o && res_o.result_kind == RK_EVENT
    && res_o.group_last, phase_q == PH_DELAY && acc_q == '0,
    "group end did not start a cleared delay")

endmodule

`default_nettype wire

/* hdl/mesp_out_stage.sv */
// ----------------------------------------------------------------------------
// mesp_out_stage
// Result register toward the output stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mesp_out_stage
  import mesp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         src_valid_i,
  input  wire logic         res_valid_i,
  input  wire mesp_result_t res_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output mesp_result_t      out_o
);

  logic         valid_q, valid_d;
  mesp_result_t res_q;

  // stage moves when empty or the beat is taken
  assign advance_o = !valid_q || out_ready_i;
  assign valid_d   = advance_o ? (src_valid_i && res_valid_i) : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire
